/* sv/cle_pkg.sv */
// ----------------------------------------------------------------------------
// Curtailment lost-energy integrator package
// Shared types, item codes and command structures.
// ----------------------------------------------------------------------------
`default_nettype none
package cle_pkg;
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_LIMIT = 2'd1;
  localparam logic [1:0] MODE_WIND  = 2'd2;
  localparam logic [1:0] MODE_CLOSE = 2'd3;

  localparam logic [1:0] REG_MAX_POWER = 2'd0;
  localparam logic [1:0] REG_USE_EXT   = 2'd1;
  localparam logic [1:0] REG_CURVE_PTS = 2'd2;

  localparam logic [23:0] MAX_POWER_RESET = 24'd3150000;
  localparam logic [62:0] E63_MAX = {63{1'b1}};

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  point_index;
    logic [15:0] curve_speed;
    logic [23:0] curve_power;
    logic [31:0] sample_time;
    logic [15:0] wind_speed;
    logic [23:0] limit_power;
    logic [31:0] window_start;
    logic [31:0] window_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] sample_count;
    logic [62:0] lost_energy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  addr;
    logic [31:0] data;
  } cfg_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic write_pt;   // write curve point
    logic set_limit;  // take limit sample
    logic scan_init;  // start search at top point
    logic scan_step;  // examine one point
    logic div_init;   // set up interpolation divide
    logic div_step;   // one quotient bit
    logic mul_lo;     // first partial product of energy
    logic mul_hi;     // second partial product of energy
    logic commit;     // update window state with wind sample
    logic close;      // form result and clear window
  } cmd_t;

  typedef struct packed {
    logic scan_done;  // search finished
    logic need_div;   // interpolation needed
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

/* sv/cle_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Generic channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface cle_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/cle_ctrl.sv */
// ----------------------------------------------------------------------------
// Integrator controller
// Sequences the search, divide and multiply steps for each wind sample, and the close.
// ----------------------------------------------------------------------------
`default_nettype none
module cle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_mode,
  input  wire logic          out_free,
  output logic               out_load,
  output cle_pkg::cmd_t      cmd,
  input  wire cle_pkg::sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIVI = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL0 = 3'd4;
  localparam logic [2:0] S_MUL1 = 3'd5;
  localparam logic [2:0] S_COMM = 3'd6;
  localparam logic [2:0] S_CLOS = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            cle_pkg::MODE_WIND: begin
              cmd.scan_init = 1'b1;
              state_next = S_SCAN;
            end
            cle_pkg::MODE_CLOSE: state_next = S_CLOS;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = sts.need_div ? S_DIVI : S_MUL0;
        else cmd.scan_step = 1'b1;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_MUL0;
        else cmd.div_step = 1'b1;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_COMM;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      S_CLOS: begin
        if (out_free) begin
          cmd.close = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* sv/cle_dp.sv */
// ----------------------------------------------------------------------------
// Integrator datapath
// Curve tables, search, bit-serial divider, energy multiply and window state.
// ----------------------------------------------------------------------------
`default_nettype none
module cle_dp #(
  parameter int MAX_CURVE_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cle_pkg::in_item_t  in_item,
  input  wire cle_pkg::cmd_t      cmd,
  output cle_pkg::sts_t           sts,
  input  wire logic [23:0]        max_power,
  input  wire logic               use_ext,
  input  wire logic [4:0]         curve_points,
  output cle_pkg::out_item_t      result
);
  localparam int AW = (MAX_CURVE_POINTS > 1) ? $clog2(MAX_CURVE_POINTS) : 1;
  localparam int CW = $clog2(MAX_CURVE_POINTS + 1);
  localparam int MAXP = MAX_CURVE_POINTS;

  logic [15:0] speed_mem [MAX_CURVE_POINTS];
  logic [23:0] power_mem [MAX_CURVE_POINTS];

  cle_pkg::in_item_t it;
  logic [23:0] held_limit;
  logic [31:0] prev_time, first_time, count_acc;
  logic        seen;
  logic [62:0] energy;

  // Effective point count and search index (index+1, zero means none).
  logic [CW-1:0] npts, idx1;
  logic [5:0]    cp_ext;
  logic          found;
  logic [15:0]   s_lo, s_hi;
  logic [23:0]   p_lo, p_hi;
  logic          rd_phase;

  assign cp_ext = {1'b0, curve_points};

  always_ff @(posedge clk) begin
    if (cmd.write_pt || (cmd.load && in_item.mode == cle_pkg::MODE_LOAD &&
        32'(in_item.point_index) < 32'(MAXP))) begin
      speed_mem[AW'(in_item.point_index)] <= in_item.curve_speed;
      power_mem[AW'(in_item.point_index)] <= in_item.curve_power;
    end
  end

  // Search: one point per step from the top; then, unless the match is the top
  // point, a further step reads the next-higher point.
  logic [AW-1:0] ridx;
  assign ridx = rd_phase ? AW'(idx1) : AW'(idx1 - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      rd_phase <= 1'b0;
      idx1 <= '0;
      npts <= '0;
    end else if (cmd.scan_init) begin
      npts <= (32'(cp_ext) > 32'(MAXP)) ? CW'(MAXP) : CW'(cp_ext);
      idx1 <= (32'(cp_ext) > 32'(MAXP)) ? CW'(MAXP) : CW'(cp_ext);
      found <= 1'b0;
      rd_phase <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!found) begin
        if (idx1 == '0) found <= 1'b1;
        else if (it.wind_speed >= speed_mem[ridx]) begin
          found <= 1'b1;
          s_lo <= speed_mem[ridx];
          p_lo <= power_mem[ridx];
          rd_phase <= (idx1 != npts);
        end else idx1 <= idx1 - CW'(1);
      end else if (rd_phase) begin
        s_hi <= speed_mem[ridx];
        p_hi <= power_mem[ridx];
        rd_phase <= 1'b0;
      end
    end
  end

  assign sts.scan_done = found && !rd_phase;
  assign sts.need_div  = (idx1 != '0) && (idx1 != npts) && (s_hi > s_lo);

  // Restoring divider: |dp|*(w-s) / (s_hi-s_lo), 40-bit dividend.
  logic [39:0] quo;
  logic [16:0] rem;
  logic [15:0] den;
  logic [5:0]  dcnt;
  logic        neg;
  logic [16:0] rem_sh;
  logic [24:0] dp_s;
  logic [23:0] dp_mag;

  assign dp_s   = {1'b0, p_hi} - {1'b0, p_lo};
  assign dp_mag = dp_s[24] ? 24'(-dp_s) : dp_s[23:0];
  assign rem_sh = {rem[15:0], quo[39]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_init) begin
      quo  <= 40'(dp_mag) * 40'(it.wind_speed - s_lo);
      rem  <= '0;
      den  <= s_hi - s_lo;
      neg  <= dp_s[24];
      dcnt <= 6'd40;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[38:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
  end
  assign sts.div_done = (dcnt == 6'd0);

  // Theoretical power from search and quotient (quotient < 2^24).
  logic [23:0] theory;
  always_comb begin
    if (idx1 == '0) theory = '0;
    else if (!sts.need_div) theory = p_lo;
    else if (neg) theory = p_lo - quo[23:0];
    else theory = p_lo + quo[23:0];
  end

  // Energy step: excess (24b) times dt (32b) in two 24x16 products.
  logic [23:0] excess;
  logic [31:0] dt;
  logic [39:0] pp_lo;
  logic [55:0] add;
  logic        gate;
  assign excess = theory - held_limit;
  assign dt     = it.sample_time - prev_time;
  assign gate   = seen && held_limit < max_power &&
                  it.sample_time >= prev_time && theory > held_limit;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) pp_lo <= 40'(excess) * 40'(dt[15:0]);
    if (cmd.mul_hi) add <= 56'(pp_lo) + {40'(excess) * 40'(dt[31:16]), 16'd0};
  end

  logic [63:0] esum;
  assign esum = {1'b0, energy} + 64'(add);

  always_ff @(posedge clk) begin
    if (cmd.load) it <= in_item;
    if (rst || cmd.close) begin
      held_limit <= '0;
      prev_time  <= '0;
      first_time <= '0;
      seen       <= 1'b0;
      count_acc  <= '0;
      energy     <= '0;
    end else begin
      if (cmd.load && in_item.mode == cle_pkg::MODE_LIMIT)
        held_limit <= in_item.limit_power;
      if (cmd.commit) begin
        if (!seen) begin
          seen <= 1'b1;
          first_time <= it.sample_time;
        end else if (gate) begin
          energy <= esum[63] ? cle_pkg::E63_MAX : esum[62:0];
        end
        prev_time <= it.sample_time;
        if (count_acc != '1) count_acc <= count_acc + 32'd1;
      end
    end
  end

  always_comb begin
    result.start_time   = use_ext ? it.window_start : (seen ? first_time : '0);
    result.end_time     = use_ext ? it.window_end : (seen ? prev_time : '0);
    result.sample_count = count_acc;
    result.lost_energy  = energy;
  end
endmodule
`default_nettype wire

/* sv/curtailment_lost_energy_integrator.sv */
// ----------------------------------------------------------------------------
// Curtailment lost-energy integrator
// Integrates energy lost to curtailment over a window of telemetry samples.
// ----------------------------------------------------------------------------
// Load and limit items are taken in the idle state and can follow back to back.
// A wind sample blocks input after its transfer while it runs the search from
// the top curve point, a divide setup and the 40-bit bit-serial divide (both
// skipped with no interpolation), then the low and high energy partial products
// and a commit. A close item loads its result once the output register is free.
// Reset (synchronous, active high) clears the window and the output valid.
`default_nettype none
module curtailment_lost_energy_integrator #(
  parameter int MAX_CURVE_POINTS = 16
) (
  input wire logic clk,
  input wire logic rst,
  cle_if.sink      in_ch,
  cle_if.source    out_ch,
  cle_if.sink      cfg
);
  logic [23:0] max_power;
  logic        use_ext;
  logic [4:0]  curve_points;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_power    <= cle_pkg::MAX_POWER_RESET;
      use_ext      <= 1'b1;
      curve_points <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        cle_pkg::REG_MAX_POWER: max_power    <= cfg.data.data[23:0];
        cle_pkg::REG_USE_EXT:   use_ext      <= cfg.data.data[0];
        cle_pkg::REG_CURVE_PTS: curve_points <= cfg.data.data[4:0];
        default: ;
      endcase
    end
  end

  cle_pkg::cmd_t     cmd;
  cle_pkg::sts_t     sts;
  cle_pkg::out_item_t res;
  logic out_load;

  cle_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.data.mode),
    .out_free(!out_ch.valid || out_ch.ready), .out_load(out_load),
    .cmd(cmd), .sts(sts)
  );

  cle_dp #(.MAX_CURVE_POINTS(MAX_CURVE_POINTS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_ch.data), .cmd(cmd), .sts(sts),
    .max_power(max_power), .use_ext(use_ext), .curve_points(curve_points),
    .result(res)
  );

  // Output register decouples the result from the downstream ready.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (out_load) out_ch.data <= res;
  end

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_ch.valid || out_ch.ready)) else $error("result overwritten");
  // Input is not accepted while a close result is being formed.
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !in_ch.ready) else $error("input taken during close");
  // Window accumulators are empty right after a close.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> (res.sample_count == 32'd0)) else $error("window not cleared");
endmodule
`default_nettype wire
